>>> rtl/core/puct_pkg.sv
// shared types and constants for the puct action selector
`default_nettype none
package puct_pkg;
  localparam int MAX_ACTIONS = 256;
  localparam int IDX_W       = $clog2(MAX_ACTIONS);
  localparam int CNT_W       = $clog2(MAX_ACTIONS + 1);
  localparam int TOTAL_W     = 28;
  localparam int RAD_W       = 46;
  localparam int ROOT_W      = RAD_W / 2;
  localparam int DVD_W       = 34;
  localparam int DVS_W       = 21;
  localparam int SCORE_W     = 36;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
  localparam logic [15:0] GAIN_RESET = 16'd5120;
  localparam logic signed [SCORE_W-1:0] BEST_START = -36'sd65536;

  typedef struct packed {
    logic signed [15:0] action_value;
    logic [19:0]        visit_count;
    logic [15:0]        prior_prob;
    logic signed [15:0] unvisited_estimate;
    logic               player_color;
    logic               turn_parity;
    logic               last_action;
  } in_word_t;

  typedef struct packed {
    logic [7:0] chosen_action;
    logic       none_found;
  } out_word_t;

  typedef struct packed {
    logic [15:0] value;
    logic [19:0] visits;
    logic [15:0] prior;
  } entry_t;

  typedef enum logic [3:0] {
    S_LOAD, S_SQRT, S_RD, S_MUL1, S_MUL2, S_DVS, S_DIV, S_NEXT, S_DONE
  } state_t;
endpackage
`default_nettype wire

>>> rtl/core/puct_store.sv
// action store: one write port, one registered read port
`default_nettype none
module puct_store (
  input  wire logic                   clk,
  input  wire logic                   we,
  input  wire logic [puct_pkg::IDX_W-1:0] waddr,
  input  wire puct_pkg::entry_t       wdata,
  input  wire logic [puct_pkg::IDX_W-1:0] raddr,
  output puct_pkg::entry_t            rdata
);
  import puct_pkg::*;
  entry_t mem [MAX_ACTIONS];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

>>> rtl/core/puct_sqrt.sv
// digit-by-digit integer square root, one result bit per cycle
`default_nettype none
module puct_sqrt (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [puct_pkg::RAD_W-1:0] radicand,
  output logic                          done,
  output logic [puct_pkg::ROOT_W-1:0]   root
);
  import puct_pkg::*;
  localparam int REM_W = ROOT_W + 4;
  localparam int STEP_W = $clog2(ROOT_W + 1);

  logic [RAD_W-1:0]  rad_r, rad_nxt;
  logic [ROOT_W-1:0] res_r, res_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [REM_W-1:0]  shifted, trial;

  always_comb begin
    rad_nxt  = rad_r;
    res_nxt  = res_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
    trial    = {2'b00, res_r, 2'b01};
    if (start) begin
      rad_nxt  = radicand;
      res_nxt  = '0;
      rem_nxt  = '0;
      step_nxt = STEP_W'(ROOT_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = {rad_r[RAD_W-3:0], 2'b00};
      if (shifted >= trial) begin
        rem_nxt = shifted - trial;
        res_nxt = {res_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        res_nxt = {res_r[ROOT_W-2:0], 1'b0};
      end
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rad_r  <= rad_nxt;
    res_r  <= res_nxt;
    rem_r  <= rem_nxt;
    step_r <= step_nxt;
  end

  assign done = done_r;
  assign root = res_r;
endmodule
`default_nettype wire

>>> rtl/core/puct_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module puct_div (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [puct_pkg::DVD_W-1:0] dividend,
  input  wire logic [puct_pkg::DVS_W-1:0] divisor,
  output logic                          done,
  output logic [puct_pkg::DVD_W-1:0]    quotient
);
  import puct_pkg::*;
  localparam int REM_W = DVS_W + 1;
  localparam int STEP_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0]  q_r, q_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [DVS_W-1:0]  d_r, d_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [REM_W-1:0]  shifted;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r[REM_W-2:0], q_r[DVD_W-1]};
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      d_nxt    = divisor;
      step_nxt = STEP_W'(DVD_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (shifted >= {1'b0, d_r}) begin
        rem_nxt = shifted - {1'b0, d_r};
        q_nxt   = {q_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        q_nxt   = {q_r[DVD_W-2:0], 1'b0};
      end
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    q_r    <= q_nxt;
    rem_r  <= rem_nxt;
    d_r    <= d_nxt;
    step_r <= step_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;
endmodule
`default_nettype wire

>>> rtl/core/puct_action_select.sv
// puct action selector top level: load, root, per-action scoring and result
//
//  channel | direction | handshake      | word
//  in_     | input     | valid / stall  | in_word_t, one action
//  out_    | output    | valid / stall  | out_word_t, winner or none
//  cfg_    | input     | valid / ready  | exploration gain, Q4.12
//
// loading accepts a word whenever in_stall is low; a word marked last then starts selection
// selection: square root, then per stored action a read, two multiplies, the
// 34-step divider and a compare; a zero-prior action is skipped after the read
// reset clears the set and the output valid; the gain returns to 1.25
// in_stall is high during selection; a pending result does not block loading
`default_nettype none
module puct_action_select (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire puct_pkg::in_word_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output puct_pkg::out_word_t      out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [15:0]         cfg_data
);
  import puct_pkg::*;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [15:0]        est_r, est_nxt;
  logic               match_r, match_nxt;
  logic [15:0]        gain_r;
  logic [ROOT_W-1:0]  root_r, root_nxt;
  logic [31:0]        prod1_r, prod1_nxt;
  logic [54:0]        prod2_r, prod2_nxt;
  logic signed [16:0] val_r, val_nxt;
  logic [19:0]        n_r, n_nxt;
  logic signed [SCORE_W-1:0] best_r, best_nxt, score;
  logic [IDX_W-1:0]   win_r, win_nxt;
  logic               found_r, found_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_word_t          out_r, out_nxt;

  logic               in_acc, we, sqrt_start, sqrt_done, div_start, div_done;
  logic [TOTAL_W:0]   sum;
  logic [TOTAL_W-1:0] total_add;
  entry_t             wentry, rentry;
  logic [ROOT_W-1:0]  root;
  logic [DVD_W-1:0]   quot;
  logic signed [16:0] v;

  assign in_stall  = (state_r != S_LOAD);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign sum       = {1'b0, total_r} + {{(TOTAL_W-19){1'b0}}, in_data.visit_count};
  assign total_add = (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[TOTAL_W-1:0];
  assign wentry    = '{value: in_data.action_value, visits: in_data.visit_count,
                       prior: in_data.prior_prob};
  assign we        = in_acc && (cnt_r < CNT_W'(MAX_ACTIONS));
  assign sqrt_start = in_acc && in_data.last_action;
  assign div_start  = (state_r == S_DVS);

  puct_store u_store (
    .clk   (clk),
    .we    (we),
    .waddr (cnt_r[IDX_W-1:0]),
    .wdata (wentry),
    .raddr (idx_r[IDX_W-1:0]),
    .rdata (rentry)
  );

  // radicand is (1 + total) << 16, total taken after this word is summed
  puct_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand ({1'b0, ({1'b0, total_nxt} + {{TOTAL_W{1'b0}}, 1'b1}), 16'd0}),
    .done     (sqrt_done),
    .root     (root)
  );

  // bonus = floor(floor(gain * p * root / 2^21) / (1 + n))
  puct_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod2_r[54:21]),
    .divisor  ({1'b0, n_r} + 21'd1),
    .done     (div_done),
    .quotient (quot)
  );

  assign score = $signed({{(SCORE_W-17){val_r[16]}}, val_r})
               + $signed({{(SCORE_W-DVD_W){1'b0}}, quot});

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    total_nxt     = total_r;
    est_nxt       = est_r;
    match_nxt     = match_r;
    root_nxt      = root_r;
    prod1_nxt     = prod1_r;
    prod2_nxt     = prod2_r;
    val_nxt       = val_r;
    n_nxt         = n_r;
    best_nxt      = best_r;
    win_nxt       = win_r;
    found_nxt     = found_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    v             = '0;
    unique case (state_r)
      S_LOAD: begin
        if (we) begin
          if (cnt_r == '0) begin
            est_nxt   = in_data.unvisited_estimate;
            match_nxt = (in_data.player_color == in_data.turn_parity);
          end
          cnt_nxt   = cnt_r + 1'b1;
          total_nxt = total_add;
        end
        if (sqrt_start) begin
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        if (sqrt_done) begin
          root_nxt  = root;
          idx_nxt   = '0;
          best_nxt  = BEST_START;
          win_nxt   = '0;
          found_nxt = 1'b0;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        if (rentry.prior == '0) begin
          state_nxt = S_NEXT;
        end else begin
          v = (rentry.visits == '0) ? {est_r[15], est_r} : {rentry.value[15], rentry.value};
          val_nxt   = match_r ? v : -v;
          n_nxt     = rentry.visits;
          prod1_nxt = gain_r * rentry.prior;
          state_nxt = S_MUL2;
        end
      end
      S_MUL2: begin
        prod2_nxt = {23'd0, prod1_r} * {32'd0, root_r};
        state_nxt = S_DVS;
      end
      S_DVS: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          if (score > best_r) begin
            best_nxt  = score;
            win_nxt   = idx_r[IDX_W-1:0];
            found_nxt = 1'b1;
          end
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        if (idx_r + 1'b1 >= cnt_r) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt.chosen_action = found_r ? 8'(win_r) : 8'd0;
          out_nxt.none_found    = !found_r;
          out_valid_nxt         = 1'b1;
          cnt_nxt               = '0;
          total_nxt             = '0;
          state_nxt             = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      total_r     <= '0;
      est_r       <= '0;
      match_r     <= 1'b0;
      gain_r      <= GAIN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      total_r     <= total_nxt;
      est_r       <= est_nxt;
      match_r     <= match_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        gain_r <= cfg_data;
      end
    end
    idx_r   <= idx_nxt;
    root_r  <= root_nxt;
    prod1_r <= prod1_nxt;
    prod2_r <= prod2_nxt;
    val_r   <= val_nxt;
    n_r     <= n_nxt;
    best_r  <= best_nxt;
    win_r   <= win_nxt;
    found_r <= found_nxt;
    out_r   <= out_nxt;
  end
endmodule
`default_nettype wire
